@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ src/sbd_pkg.sv @@
// Types and codes for the sortable bounded deque.
`timescale 1ns / 1ps

package sbd_pkg;

    localparam int AMT_W = 16;

    localparam logic [2:0] OP_ADD_FRONT = 3'd0;
    localparam logic [2:0] OP_ADD_END   = 3'd1;
    localparam logic [2:0] OP_REMOVE    = 3'd2;
    localparam logic [2:0] OP_SORT      = 3'd3;
    localparam logic [2:0] OP_ROT_LEFT  = 3'd4;
    localparam logic [2:0] OP_ROT_RIGHT = 3'd5;
    localparam logic [2:0] OP_DUMP      = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_POS  = 2'd2;

    typedef struct packed {
        logic [2:0]        op;
        logic signed [31:0] value;
        logic [AMT_W-1:0]  amount;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] element;
        logic               element_valid;
        logic [4:0]         count;
        logic [1:0]         status;
        logic               last;
    } t_rsp;

endpackage

@@ src/sbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/sortable_bounded_deque.sv @@
// Top level of the sortable bounded deque: sequencer, store and result register.
`timescale 1ns / 1ps

// Sortable bounded deque holding up to DEPTH signed 32-bit values.
// Command channel i_in_valid/o_in_stall carries op, value and amount; a
// transfer happens when valid is high and stall low. One command is worked
// at a time: o_in_stall stays high until its last result is loaded.
// Result channel o_out_valid/i_out_stall is a single output register; a
// stalled result holds and the sequencer waits for the register to free.
// Work per command, bound by the single store port pair:
//   add front/end, bad remove, empty rotate or dump, unused op: straight to the result
//   remove at p: each later element read and written one place toward the head
//   sort: insertion sort, one read and write per element shifted
//   rotate: amount mod n, then k left steps, k the effective step count (k < n)
//   dump: one read and one result per element, head first, last set on the tail
// Synchronous active-low reset empties the deque and drops any pending
// result; store contents are not cleared.
module sortable_bounded_deque #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sbd_pkg::t_cmd i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sbd_pkg::t_rsp o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > sbd_pkg::AMT_W) ? CW : sbd_pkg::AMT_W;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_REM_CHK  = 14'b00000000000010,
        S_REM_WR   = 14'b00000000000100,
        S_SRT_NEXT = 14'b00000000001000,
        S_SRT_LDX  = 14'b00000000010000,
        S_SRT_CHK  = 14'b00000000100000,
        S_SRT_CMP  = 14'b00000001000000,
        S_MOD      = 14'b00000010000000,
        S_ROT_SET  = 14'b00000100000000,
        S_ROT_CHK  = 14'b00001000000000,
        S_ROT_WR   = 14'b00010000000000,
        S_DMP_RD   = 14'b00100000000000,
        S_DMP_OUT  = 14'b01000000000000,
        S_RESP     = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_first, n_first;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_rem, n_rem;
    logic [sbd_pkg::AMT_W-1:0] r_amt, n_amt;
    logic [3:0] r_bit, n_bit;
    logic r_right, n_right;
    logic [31:0] r_x, n_x;
    logic [1:0] r_status, n_status;
    logic r_out_valid, n_out_valid;
    sbd_pkg::t_rsp r_out_data, n_out_data;

    logic ram_we, ram_re, wr_front;
    logic [AW-1:0] ram_waddr, ram_raddr, front_slot;
    logic [31:0] ram_wdata, ram_rdata;
    logic [CW-1:0] rd_pos, wr_pos;
    logic out_free, is_full;
    logic [CW:0] rem_sh;
    logic [MW-1:0] amt_w, cnt_w;
    logic [CW+4:0] cnt_wide;

    // Position in the sequence to physical slot; sum stays below 2*DEPTH.
    function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] f, input logic [CW-1:0] p);
        logic [CW:0] s;
        s = (CW+1)'(f) + (CW+1)'(p);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    sbd_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign is_full    = (r_count >= CW'(DEPTH));
    assign front_slot = (r_first == '0) ? AW'(DEPTH - 1) : r_first - AW'(1);
    assign ram_raddr  = slot_f(r_first, rd_pos);
    assign ram_waddr  = wr_front ? front_slot : slot_f(r_first, wr_pos);
    assign rem_sh     = {r_rem, r_amt[sbd_pkg::AMT_W-1]};
    assign amt_w      = MW'(i_in_data.amount);
    assign cnt_w      = MW'(r_count);
    assign cnt_wide   = {5'b0, r_count};

    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_count     = r_count;
        n_idx       = r_idx;
        n_j         = r_j;
        n_rem       = r_rem;
        n_amt       = r_amt;
        n_bit       = r_bit;
        n_right     = r_right;
        n_x         = r_x;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        wr_front    = 1'b0;
        wr_pos      = '0;
        rd_pos      = '0;
        ram_wdata   = r_x;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = sbd_pkg::ST_OK;
                    n_right  = (i_in_data.op == sbd_pkg::OP_ROT_RIGHT);
                    n_state  = S_RESP;
                    case (i_in_data.op)
                        sbd_pkg::OP_ADD_FRONT: begin
                            if (is_full) begin
                                n_status = sbd_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                wr_front  = 1'b1;
                                ram_wdata = i_in_data.value;
                                n_first   = front_slot;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        sbd_pkg::OP_ADD_END: begin
                            if (is_full) begin
                                n_status = sbd_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                wr_pos    = r_count;
                                ram_wdata = i_in_data.value;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        sbd_pkg::OP_REMOVE: begin
                            if (amt_w == '0 || amt_w > cnt_w) begin
                                n_status = sbd_pkg::ST_POS;
                            end else begin
                                n_idx   = CW'(amt_w - MW'(1));
                                n_state = S_REM_CHK;
                            end
                        end
                        sbd_pkg::OP_SORT: begin
                            n_idx   = CW'(1);
                            n_state = S_SRT_NEXT;
                        end
                        sbd_pkg::OP_ROT_LEFT, sbd_pkg::OP_ROT_RIGHT: begin
                            if (r_count != '0) begin
                                n_rem   = '0;
                                n_amt   = i_in_data.amount;
                                n_bit   = '0;
                                n_state = S_MOD;
                            end
                        end
                        sbd_pkg::OP_DUMP: begin
                            if (r_count != '0) begin
                                n_idx   = '0;
                                n_state = S_DMP_RD;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            // remove: pull each later element one place toward the head
            S_REM_CHK: begin
                if (({1'b0, r_idx} + (CW+1)'(1)) < {1'b0, r_count}) begin
                    ram_re  = 1'b1;
                    rd_pos  = r_idx + CW'(1);
                    n_state = S_REM_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_first = '0;
                    end
                    n_state = S_RESP;
                end
            end
            S_REM_WR: begin
                ram_we    = 1'b1;
                wr_pos    = r_idx;
                ram_wdata = ram_rdata;
                n_idx     = r_idx + CW'(1);
                n_state   = S_REM_CHK;
            end
            // insertion sort, one compare per element visited
            S_SRT_NEXT: begin
                if (r_idx < r_count) begin
                    ram_re  = 1'b1;
                    rd_pos  = r_idx;
                    n_j     = r_idx;
                    n_state = S_SRT_LDX;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SRT_LDX: begin
                n_x     = ram_rdata;
                n_state = S_SRT_CHK;
            end
            S_SRT_CHK: begin
                if (r_j == '0) begin
                    ram_we  = 1'b1;
                    wr_pos  = '0;
                    n_idx   = r_idx + CW'(1);
                    n_state = S_SRT_NEXT;
                end else begin
                    ram_re  = 1'b1;
                    rd_pos  = r_j - CW'(1);
                    n_state = S_SRT_CMP;
                end
            end
            S_SRT_CMP: begin
                ram_we = 1'b1;
                wr_pos = r_j;
                if ($signed(r_x) < $signed(ram_rdata)) begin
                    ram_wdata = ram_rdata;
                    n_j       = r_j - CW'(1);
                    n_state   = S_SRT_CHK;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_SRT_NEXT;
                end
            end
            // amount mod count, one quotient bit per cycle
            S_MOD: begin
                if (rem_sh >= {1'b0, r_count}) begin
                    n_rem = CW'(rem_sh - {1'b0, r_count});
                end else begin
                    n_rem = rem_sh[CW-1:0];
                end
                n_amt = r_amt << 1;
                n_bit = r_bit + 4'd1;
                if (r_bit == 4'd15) begin
                    n_state = S_ROT_SET;
                end
            end
            S_ROT_SET: begin
                if (r_right && r_rem != '0) begin
                    n_j = r_count - r_rem;
                end else begin
                    n_j = r_rem;
                end
                n_state = S_ROT_CHK;
            end
            // one left step: head moves to the slot past the tail
            S_ROT_CHK: begin
                if (r_j == '0) begin
                    n_state = S_RESP;
                end else begin
                    ram_re  = 1'b1;
                    rd_pos  = '0;
                    n_state = S_ROT_WR;
                end
            end
            S_ROT_WR: begin
                ram_we    = 1'b1;
                wr_pos    = r_count;
                ram_wdata = ram_rdata;
                n_first   = slot_f(r_first, CW'(1));
                n_j       = r_j - CW'(1);
                n_state   = S_ROT_CHK;
            end
            S_DMP_RD: begin
                ram_re  = 1'b1;
                rd_pos  = r_idx;
                n_state = S_DMP_OUT;
            end
            S_DMP_OUT: begin
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_data.element         = ram_rdata;
                    n_out_data.element_valid   = 1'b1;
                    n_out_data.count           = cnt_wide[4:0];
                    n_out_data.status          = sbd_pkg::ST_OK;
                    n_out_data.last            =
                        (({1'b0, r_idx} + (CW+1)'(1)) == {1'b0, r_count});
                    n_idx                      = r_idx + CW'(1);
                    n_state                    = n_out_data.last ? S_IDLE : S_DMP_RD;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_data.element       = '0;
                    n_out_data.element_valid = 1'b0;
                    n_out_data.count         = cnt_wide[4:0];
                    n_out_data.status        = r_status;
                    n_out_data.last          = 1'b1;
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_j        <= n_j;
        r_rem      <= n_rem;
        r_amt      <= n_amt;
        r_bit      <= n_bit;
        r_right    <= n_right;
        r_x        <= n_x;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ src/sbd_checker.sv @@
// Port-level checks for the sortable bounded deque, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbd_checker #(
    parameter int DEPTH = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input sbd_pkg::t_cmd i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input sbd_pkg::t_rsp o_out_data
);

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    `ASSERT_CLK(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)), "stalled result changed")

    // an accepted command always makes the block busy, raising o_in_stall
    `ASSERT_CLK(a_busy_after_xfer, in_xfer |=> o_in_stall, "command transfer not followed by busy")

    // results without an element are zero and close the command
    `ASSERT_CLK(a_no_elem_last, (o_out_valid && !o_out_data.element_valid) |-> (o_out_data.element == '0 && o_out_data.last), "empty result malformed")

    `ASSERT_CLK(a_count_bound, o_out_valid |-> (int'(o_out_data.count) <= DEPTH), "count beyond depth")

    `ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind sortable_bounded_deque sbd_checker #(.DEPTH(DEPTH)) u_sbd_checker (.*);
